/* rtl/core/pfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and the control store of the PID unit.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // Errors of this magnitude or less count as zero
  localparam logic [31:0] ErrorDeadband = 32'd0;

  localparam logic [16:0] OneQ16 = 17'd65536;

  // Configuration register indexes
  localparam logic [2:0] REG_KP            = 3'd0;
  localparam logic [2:0] REG_KI_TS         = 3'd1;
  localparam logic [2:0] REG_KD            = 3'd2;
  localparam logic [2:0] REG_DERIV_ALPHA   = 3'd3;
  localparam logic [2:0] REG_ALPHA_OVER_TS = 3'd4;
  localparam logic [2:0] REG_DERIV_LIMIT   = 3'd5;
  localparam logic [2:0] REG_OUT_MAX       = 3'd6;
  localparam logic [2:0] REG_OUT_MIN       = 3'd7;

  typedef struct packed {
    logic [30:0]        kp;
    logic [30:0]        ki_ts;
    logic [30:0]        kd;
    logic [16:0]        deriv_alpha;
    logic [30:0]        alpha_over_ts;
    logic [30:0]        deriv_limit;
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
  } cfg_t;

  // Microprogram steps
  localparam int StepW = 4;
  localparam logic [StepW-1:0] STEP_IDLE  = 4'd0;  // take a request
  localparam logic [StepW-1:0] STEP_FILT  = 4'd1;  // (1-alpha) * fd
  localparam logic [StepW-1:0] STEP_DIFF  = 4'd2;  // alpha/ts * (e - e_prev)
  localparam logic [StepW-1:0] STEP_PROP  = 4'd3;  // kp * e
  localparam logic [StepW-1:0] STEP_FDUP  = 4'd4;  // clamp fd, ki_ts * e
  localparam logic [StepW-1:0] STEP_DMUL  = 4'd5;  // kd * fd, new integral
  localparam logic [StepW-1:0] STEP_PDSUM = 4'd6;  // P + D
  localparam logic [StepW-1:0] STEP_YSUM  = 4'd7;  // P + D + I
  localparam logic [StepW-1:0] STEP_FIN   = 4'd8;  // limit, anti-windup, emit

  typedef enum logic [1:0] {
    WT_NONE,
    WT_IN,
    WT_OUT
  } wait_e;

  typedef enum logic [2:0] {
    MS_FILT,
    MS_DIFF,
    MS_PROP,
    MS_INTG,
    MS_DERV
  } mul_sel_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ADD
  } sum_op_e;

  typedef struct packed {
    logic             in_rdy;
    wait_e            wt;
    mul_sel_e         msel;
    sum_op_e          acc_op;
    logic             fd_ld;
    logic             int_ld;
    sum_op_e          pd_op;
    logic             y_ld;
    logic             fin;
    logic [StepW-1:0] nxt;
  } ctl_t;

  typedef struct packed {
    ctl_t w;
    logic go;
  } seq_t;

  localparam ctl_t CtlNop = '{
    in_rdy: 1'b0, wt: WT_NONE, msel: MS_FILT, acc_op: OP_HOLD, fd_ld: 1'b0,
    int_ld: 1'b0, pd_op: OP_HOLD, y_ld: 1'b0, fin: 1'b0, nxt: STEP_IDLE
  };

  function automatic ctl_t ucode(logic [StepW-1:0] step);
    ctl_t w;
    w = CtlNop;
    case (step)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.wt     = WT_IN;
        w.nxt    = STEP_FILT;
      end
      STEP_FILT: begin
        w.msel = MS_FILT;
        w.nxt  = STEP_DIFF;
      end
      STEP_DIFF: begin
        w.msel   = MS_DIFF;
        w.acc_op = OP_LOAD;
        w.nxt    = STEP_PROP;
      end
      STEP_PROP: begin
        w.msel   = MS_PROP;
        w.acc_op = OP_ADD;
        w.nxt    = STEP_FDUP;
      end
      STEP_FDUP: begin
        w.msel  = MS_INTG;
        w.fd_ld = 1'b1;
        w.pd_op = OP_LOAD;
        w.nxt   = STEP_DMUL;
      end
      STEP_DMUL: begin
        w.msel   = MS_DERV;
        w.int_ld = 1'b1;
        w.nxt    = STEP_PDSUM;
      end
      STEP_PDSUM: begin
        w.pd_op = OP_ADD;
        w.nxt   = STEP_YSUM;
      end
      STEP_YSUM: begin
        w.y_ld = 1'b1;
        w.nxt  = STEP_FIN;
      end
      STEP_FIN: begin
        w.wt  = WT_OUT;
        w.fin = 1'b1;
        w.nxt = STEP_IDLE;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/pfd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_in_if
// Error sample channel: valid/ready with one signed Q16.16 error.
// ----------------------------------------------------------------------------
interface pfd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] error;

  modport source (output valid, output error, input ready);
  modport sink   (input valid, input error, output ready);
endinterface

/* rtl/core/pfd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_out_if
// Result channel: limited drive value plus limit and anti-windup flags.
// ----------------------------------------------------------------------------
interface pfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               limited;
  logic               windup_held;

  modport source (output valid, output drive, output limited, output windup_held,
                  input ready);
  modport sink   (input valid, input drive, input limited, input windup_held,
                  output ready);
endinterface

/* rtl/core/pid_filtered_derivative_antiwindup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup_unit
// Fixed-point PID with filtered derivative and clamping anti-windup.
// ----------------------------------------------------------------------------
// One signed Q16.16 error request in gives one result out: the limited drive
// and two flags. A sample runs through the steps of the microprogram in the
// control store, set by the single shared 33x33 multiplier, which forms one
// product per multiply step (filter decay, error difference, P, I and D),
// followed by the sums and the output limit. A new request is taken only in
// the idle step, once the previous one has run through every step, while its
// result may still sit in the output register; the final step only waits if
// that register is still full. Products are floored to Q16.16; the integral
// saturates to 32 bits, filter state is clamped to the derivative limit.
// The user must write registers only while the unit is idle; the unit does
// not enforce this. Reset clears integral, previous error and filter state.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pfd_in_if.sink      err_i,
  pfd_out_if.source   res_o
);

  pfd_pkg::cfg_t cfg_q;
  pfd_pkg::seq_t seq;
  logic          out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp            <= '0;
      cfg_q.ki_ts         <= '0;
      cfg_q.kd            <= '0;
      cfg_q.deriv_alpha   <= pfd_pkg::OneQ16;
      cfg_q.alpha_over_ts <= '0;
      cfg_q.deriv_limit   <= 31'h7FFF_FFFF;
      cfg_q.out_max       <= 32'sh7FFF_FFFF;
      cfg_q.out_min       <= 32'sh8000_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfd_pkg::REG_KP:            cfg_q.kp            <= cfg_data_i[30:0];
        pfd_pkg::REG_KI_TS:         cfg_q.ki_ts         <= cfg_data_i[30:0];
        pfd_pkg::REG_KD:            cfg_q.kd            <= cfg_data_i[30:0];
        pfd_pkg::REG_DERIV_ALPHA:   cfg_q.deriv_alpha   <= cfg_data_i[16:0];
        pfd_pkg::REG_ALPHA_OVER_TS: cfg_q.alpha_over_ts <= cfg_data_i[30:0];
        pfd_pkg::REG_DERIV_LIMIT:   cfg_q.deriv_limit   <= cfg_data_i[30:0];
        pfd_pkg::REG_OUT_MAX:       cfg_q.out_max       <= $signed(cfg_data_i);
        pfd_pkg::REG_OUT_MIN:       cfg_q.out_min       <= $signed(cfg_data_i);
        default:                    cfg_q               <= cfg_q;
      endcase
    end
  end

  // Sequencer: step counter and control store
  pfd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (err_i.valid),
    .out_free_i (out_free),
    .seq_o      (seq)
  );

  // Datapath driven by the current control word
  pfd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .seq_i      (seq),
    .out_free_o (out_free),
    .in_if      (err_i),
    .out_if     (res_o)
  );

endmodule

/* rtl/core/pfd_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_seq
// Step counter and control store; holds a step while its wait test fails.
// ----------------------------------------------------------------------------
module pfd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  output pfd_pkg::seq_t  seq_o
);

  logic [pfd_pkg::StepW-1:0] step_q, step_d;
  pfd_pkg::ctl_t             word;
  logic                      hold;

  always_comb begin
    word = pfd_pkg::ucode(step_q);
    case (word.wt)
      pfd_pkg::WT_IN:  hold = !in_valid_i;
      pfd_pkg::WT_OUT: hold = !out_free_i;
      default:         hold = 1'b0;
    endcase
    step_d   = hold ? step_q : word.nxt;
    seq_o.w  = word;
    seq_o.go = !hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pfd_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* rtl/core/pfd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_dp
// Datapath: one shared 33x33 multiplier, accumulators, state and result reg.
// ----------------------------------------------------------------------------
module pfd_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfd_pkg::cfg_t    cfg_i,
  input  pfd_pkg::seq_t    seq_i,
  output logic             out_free_o,
  pfd_in_if.sink           in_if,
  pfd_out_if.source        out_if
);

  localparam logic signed [50:0] S32Max = 51'sd2147483647;
  localparam logic signed [50:0] S32Min = -51'sd2147483648;

  function automatic logic signed [31:0] sat32(logic signed [50:0] x);
    logic signed [50:0] r;
    if (x > S32Max) begin
      r = S32Max;
    end else if (x < S32Min) begin
      r = S32Min;
    end else begin
      r = x;
    end
    return r[31:0];
  endfunction

  // State
  logic signed [31:0] int_q, prev_q, fd_q;
  // Working registers
  logic signed [31:0] e_q, newint_q;
  logic signed [47:0] mul_q;
  logic signed [48:0] acc_q, pd_q;
  logic signed [49:0] y_q;
  // Result register
  logic               out_valid_q;
  logic signed [31:0] drive_q;
  logic               lim_q, held_q;

  logic               adv;
  logic signed [31:0] e_db;
  logic [16:0]        alpha_eff, one_m_alpha;
  logic signed [32:0] diff, op_a, op_b;
  logic signed [65:0] prod;
  logic signed [48:0] lim49, fd_clamp;
  logic               hi, lo, held;
  logic signed [31:0] limv, back;

  assign adv = seq_i.go;

  // Deadband on the incoming sample
  always_comb begin
    if (in_if.error >= -$signed(pfd_pkg::ErrorDeadband) &&
        in_if.error <= $signed(pfd_pkg::ErrorDeadband)) begin
      e_db = '0;
    end else begin
      e_db = in_if.error;
    end
  end

  // Multiplier operand selection
  always_comb begin
    alpha_eff   = (cfg_i.deriv_alpha > pfd_pkg::OneQ16) ? pfd_pkg::OneQ16
                                                        : cfg_i.deriv_alpha;
    one_m_alpha = pfd_pkg::OneQ16 - alpha_eff;
    diff        = 33'(e_q) - 33'(prev_q);
    case (seq_i.w.msel)
      pfd_pkg::MS_FILT: begin
        op_a = $signed({16'd0, one_m_alpha});
        op_b = 33'(fd_q);
      end
      pfd_pkg::MS_DIFF: begin
        op_a = $signed({2'b00, cfg_i.alpha_over_ts});
        op_b = diff;
      end
      pfd_pkg::MS_PROP: begin
        op_a = $signed({2'b00, cfg_i.kp});
        op_b = 33'(e_q);
      end
      pfd_pkg::MS_INTG: begin
        op_a = $signed({2'b00, cfg_i.ki_ts});
        op_b = 33'(e_q);
      end
      pfd_pkg::MS_DERV: begin
        op_a = $signed({2'b00, cfg_i.kd});
        op_b = 33'(fd_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = op_a * op_b;
  end

  // Derivative clamp to +/- limit
  always_comb begin
    lim49 = $signed({18'd0, cfg_i.deriv_limit});
    if (acc_q > lim49) begin
      fd_clamp = lim49;
    end else if (acc_q < -lim49) begin
      fd_clamp = -lim49;
    end else begin
      fd_clamp = acc_q;
    end
  end

  // Output limit and back-calculation
  always_comb begin
    hi   = y_q > 50'(cfg_i.out_max);
    lo   = !hi && (y_q < 50'(cfg_i.out_min));
    limv = hi ? cfg_i.out_max : cfg_i.out_min;
    held = (hi && (pd_q < 49'(cfg_i.out_max))) || (lo && (pd_q > 49'(cfg_i.out_min)));
    back = sat32(51'(limv) - 51'(pd_q));
  end

  assign out_free_o = !out_valid_q || out_if.ready;

  // Product is floored by the arithmetic shift; magnitude stays below 2^63
  always_ff @(posedge clk_i) begin
    mul_q <= prod[63:16];
    if (seq_i.w.in_rdy && adv) begin
      e_q <= e_db;
    end
    case (seq_i.w.acc_op)
      pfd_pkg::OP_LOAD: acc_q <= 49'(mul_q);
      pfd_pkg::OP_ADD:  acc_q <= acc_q + 49'(mul_q);
      default:          acc_q <= acc_q;
    endcase
    case (seq_i.w.pd_op)
      pfd_pkg::OP_LOAD: pd_q <= 49'(mul_q);
      pfd_pkg::OP_ADD:  pd_q <= pd_q + 49'(mul_q);
      default:          pd_q <= pd_q;
    endcase
    if (seq_i.w.int_ld) begin
      newint_q <= sat32(51'(int_q) + 51'(mul_q));
    end
    if (seq_i.w.y_ld) begin
      y_q <= 50'(pd_q) + 50'(newint_q);
    end
    if (seq_i.w.fin && adv) begin
      drive_q <= (hi || lo) ? limv : y_q[31:0];
      lim_q   <= hi || lo;
      held_q  <= held;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q       <= '0;
      prev_q      <= '0;
      fd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (seq_i.w.fd_ld) begin
        fd_q   <= fd_clamp[31:0];
        prev_q <= e_q;
      end
      if (seq_i.w.fin && adv) begin
        int_q       <= held ? back : newint_q;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_if.ready        = seq_i.w.in_rdy;
  assign out_if.valid       = out_valid_q;
  assign out_if.drive       = drive_q;
  assign out_if.limited     = lim_q;
  assign out_if.windup_held = held_q;

endmodule

/* tb/pid_filtered_derivative_antiwindup_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup_unit_tb
// Self-checking bench for the fixed-point PID with filtered derivative and
// clamping anti-windup. A short table of directed requests and register
// writes comes first, then randomised register settings, each followed by a
// stream of error requests. Every accepted request is run through a
// behavioural copy of the controller, and each result is checked in order,
// field by field. Both channel ends idle at random, the result side holds
// off once for a long stretch, and the last setting runs at full rate.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_unit_tb;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  localparam int RAND_SETTINGS   = 9;
  localparam int REQS_PER_SET    = 150;
  localparam int HOLD_CYCLES     = 200;   // long result-side hold-off
  localparam int SETTLE_CYCLES   = 3;     // margin before register writes
  localparam int TAIL_CYCLES     = 20;
  localparam int STALL_LIMIT     = 3000;  // cycles without any handshake
  localparam int HOLD_SETTING    = 3;
  localparam int PAUSE_SETTING   = 5;

  localparam longint ONE_Q      = 64'sd65536;
  localparam longint S32_MAX_L  = 64'sd2147483647;
  localparam longint S32_MIN_L  = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] drive;
    logic        limited;
    logic        windup_held;
  } drive_result_t;

  // One per offered request: a typed-in answer, or none (use the predictor)
  typedef struct packed {
    logic          typed;
    drive_result_t res;
  } request_note_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [2:0]    idx;
    logic [31:0]   value;    // register data, or the error sample
    logic          typed;
    drive_result_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  pfd_in_if  err_if ();
  pfd_out_if res_if ();

  pid_filtered_derivative_antiwindup_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .err_i      (err_if),
    .res_o      (res_if)
  );

  // Shadow of the register file and of the controller state
  pfd_pkg::cfg_t shadow_cfg;
  longint integ_acc;
  longint prev_err;
  longint filt_deriv;

  drive_result_t pending_drive[$];   // expected results, oldest first
  request_note_t request_notes[$];   // one per request not yet accepted
  stim_row_t     stim_rows[$];

  int  fail_count;
  int  requests_sent;
  int  results_seen;
  int  limited_seen;
  int  windup_seen;
  int  settings_used;
  int  stall_cycles;
  int  err_walk;
  bit  idle_on;
  bit  hold_req;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioural controller
  // --------------------------------------------------------------------------
  // Q16.16 product, floored: arithmetic shift of the exact 64-bit product
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint sat32(longint x);
    if (x > S32_MAX_L) return S32_MAX_L;
    if (x < S32_MIN_L) return S32_MIN_L;
    return x;
  endfunction

  // Advances the shadow state by one error sample and returns the result
  function automatic drive_result_t step_controller(logic signed [31:0] err_s);
    longint e, db, alpha, lim, fd, p_term, d_term, pd, new_int, y;
    longint hi, lo;
    drive_result_t r;
    e  = longint'(err_s);
    db = longint'(pfd_pkg::ErrorDeadband);
    hi = longint'(shadow_cfg.out_max);
    lo = longint'(shadow_cfg.out_min);
    r.limited     = 1'b0;
    r.windup_held = 1'b0;

    if (e >= -db && e <= db) e = 0;

    p_term = qmul(longint'(shadow_cfg.kp), e);

    // alpha above one behaves as exactly one
    alpha = longint'(shadow_cfg.deriv_alpha);
    if (alpha > ONE_Q) alpha = ONE_Q;
    fd = qmul(ONE_Q - alpha, filt_deriv)
       + qmul(longint'(shadow_cfg.alpha_over_ts), e - prev_err);
    lim = longint'(shadow_cfg.deriv_limit);
    if (fd > lim)
      fd = lim;
    else if (fd < -lim)
      fd = -lim;
    filt_deriv = fd;
    d_term     = qmul(fd, longint'(shadow_cfg.kd));
    prev_err   = e;

    new_int = sat32(integ_acc + qmul(e, longint'(shadow_cfg.ki_ts)));
    pd      = p_term + d_term;
    y       = pd + new_int;

    // upper limit tested first, which decides inverted limits
    if (y > hi) begin
      y = hi;
      r.limited = 1'b1;
      if (pd < y) r.windup_held = 1'b1;
    end else if (y < lo) begin
      y = lo;
      r.limited = 1'b1;
      if (pd > y) r.windup_held = 1'b1;
    end

    integ_acc = r.windup_held ? sat32(y - pd) : new_int;
    r.drive   = y[31:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_write(logic [2:0] idx, logic [31:0] value);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    stim_rows.push_back(row);
  endfunction

  // typed = 0 leaves the answer to the predictor
  function automatic void add_sample(logic [31:0] err, logic typed,
                                     logic [31:0] drive, logic lim, logic held);
    stim_row_t row;
    row                 = '0;
    row.kind            = ROW_SAMPLE;
    row.value           = err;
    row.typed           = typed;
    row.res.drive       = drive;
    row.res.limited     = lim;
    row.res.windup_held = held;
    stim_rows.push_back(row);
  endfunction

  // Register write; lands at the next rising edge, caller lowers the enable
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      pfd_pkg::REG_KP:            shadow_cfg.kp            = data[30:0];
      pfd_pkg::REG_KI_TS:         shadow_cfg.ki_ts         = data[30:0];
      pfd_pkg::REG_KD:            shadow_cfg.kd            = data[30:0];
      pfd_pkg::REG_DERIV_ALPHA:   shadow_cfg.deriv_alpha   = data[16:0];
      pfd_pkg::REG_ALPHA_OVER_TS: shadow_cfg.alpha_over_ts = data[30:0];
      pfd_pkg::REG_DERIV_LIMIT:   shadow_cfg.deriv_limit   = data[30:0];
      pfd_pkg::REG_OUT_MAX:       shadow_cfg.out_max       = data;
      pfd_pkg::REG_OUT_MIN:       shadow_cfg.out_min       = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one request and holds it until taken; maybe idles afterwards
  task automatic send_request(input logic [31:0] err, input request_note_t note);
    request_notes.push_back(note);
    err_if.valid <= 1'b1;
    err_if.error <= err;
    @(posedge clk_i);
    while (!err_if.ready) @(posedge clk_i);
    requests_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      err_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits for every outstanding result
  task automatic wait_all_results();
    err_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      5:       return {1'b0, 31'($urandom)};
      default: return 32'($urandom_range(0, 3 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_reg_value(logic [2:0] idx);
    logic [31:0] v;
    int          m;
    case (idx)
      pfd_pkg::REG_DERIV_ALPHA: begin
        case ($urandom_range(0, 4))
          0:       v = 32'd0;
          1:       v = 32'd65536;
          2:       v = 32'($urandom_range(65537, 17'h1FFFF));
          default: v = 32'($urandom_range(0, 65536));
        endcase
        // bits above the register width are dropped by the unit
        if ($urandom_range(0, 3) == 0) v[31:17] = 15'($urandom);
      end
      pfd_pkg::REG_DERIV_LIMIT: begin
        case ($urandom_range(0, 5))
          0:       v = 32'd0;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'd1;
          default: v = 32'($urandom_range(1, 50 << 16));
        endcase
      end
      pfd_pkg::REG_OUT_MAX, pfd_pkg::REG_OUT_MIN: begin
        m = $urandom_range(1 << 16, 200 << 16);
        case ($urandom_range(0, 7))
          0:       v = (idx == pfd_pkg::REG_OUT_MAX) ? 32'h7FFF_FFFF : 32'h8000_0000;
          1:       v = (idx == pfd_pkg::REG_OUT_MAX) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          2:       v = $urandom;
          3:       v = (idx == pfd_pkg::REG_OUT_MAX) ? 32'(-m) : 32'(m);   // inverted
          default: v = (idx == pfd_pkg::REG_OUT_MAX) ? 32'(m) : 32'(-m);
        endcase
      end
      default: v = rand_gain();
    endcase
    // top bit of the 31-bit registers is ignored
    if (idx != pfd_pkg::REG_OUT_MAX && idx != pfd_pkg::REG_OUT_MIN &&
        idx != pfd_pkg::REG_DERIV_ALPHA)
      v[31] = 1'($urandom);
    return v;
  endfunction

  task automatic apply_random_settings();
    int i;
    for (i = 0; i < 8; i++) write_reg(3'(i), rand_reg_value(3'(i)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // Mostly a slow random walk so the filter and integrator see plausible
  // signals; the rest is full-range noise, extremes and tiny values.
  function automatic logic [31:0] next_error();
    int delta;
    case ($urandom_range(0, 9))
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0001;
          3:       return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
      9: return 32'($urandom_range(0, 512) - 256);
      default: begin
        delta    = int'($urandom_range(0, 2 << 16)) - (1 << 16);
        err_walk = err_walk + delta;
        if (err_walk >  (40 << 16)) err_walk =  (40 << 16);
        if (err_walk < -(40 << 16)) err_walk = -(40 << 16);
        return 32'(err_walk);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  task automatic build_directed();
    // after reset every gain is zero, so the drive stays at zero
    add_sample(32'h0000_0000, 1'b1, 32'd0, 1'b0, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0, 1'b0);
    add_sample(32'h8000_0000, 1'b1, 32'd0, 1'b0, 1'b0);
    add_sample(32'h0001_0000, 1'b1, 32'd0, 1'b0, 1'b0);

    // unit P gain against +/-100.0 limits: clamps with no anti-windup
    add_write(pfd_pkg::REG_KP,      32'h0001_0000);
    add_write(pfd_pkg::REG_OUT_MAX, 32'h0064_0000);
    add_write(pfd_pkg::REG_OUT_MIN, 32'hFF9C_0000);
    add_sample(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b1, 32'h0064_0000, 1'b1, 1'b0);
    add_sample(32'h8000_0000, 1'b1, 32'hFF9C_0000, 1'b1, 1'b0);
    add_sample(32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0, 1'b0);

    // alpha above one, zero derivative limit, full-scale integral gain:
    // the integral runs into saturation both ways
    add_write(pfd_pkg::REG_KP,            32'h0000_0000);
    add_write(pfd_pkg::REG_KI_TS,         32'h7FFF_FFFF);
    add_write(pfd_pkg::REG_KD,            32'h0001_0000);
    add_write(pfd_pkg::REG_DERIV_ALPHA,   32'h0001_FFFF);
    add_write(pfd_pkg::REG_ALPHA_OVER_TS, 32'h7FFF_FFFF);
    add_write(pfd_pkg::REG_DERIV_LIMIT,   32'h0000_0000);
    add_write(pfd_pkg::REG_OUT_MAX,       32'h7FFF_FFFF);
    add_write(pfd_pkg::REG_OUT_MIN,       32'h8000_0000);
    repeat (3) add_sample(32'h7FFF_FFFF, 1'b0, '0, 1'b0, 1'b0);
    repeat (3) add_sample(32'h8000_0000, 1'b0, '0, 1'b0, 1'b0);

    // inverted limits, alpha zero, widest derivative limit
    add_write(pfd_pkg::REG_DERIV_LIMIT, 32'h7FFF_FFFF);
    add_write(pfd_pkg::REG_DERIV_ALPHA, 32'h0000_0000);
    add_write(pfd_pkg::REG_KP,          32'h7FFF_FFFF);
    add_write(pfd_pkg::REG_KI_TS,       32'h0000_0100);
    add_write(pfd_pkg::REG_OUT_MAX,     32'hFFFF_0000);
    add_write(pfd_pkg::REG_OUT_MIN,     32'h0001_0000);
    add_sample(32'h0000_0000, 1'b0, '0, 1'b0, 1'b0);
    add_sample(32'h0000_8000, 1'b0, '0, 1'b0, 1'b0);
    add_sample(32'hFFFF_8000, 1'b0, '0, 1'b0, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b0, '0, 1'b0, 1'b0);

    // pure integrator into +/-10.0: back-calculation on the upper limit
    add_write(pfd_pkg::REG_KP,            32'h0000_0000);
    add_write(pfd_pkg::REG_KD,            32'h0000_0000);
    add_write(pfd_pkg::REG_ALPHA_OVER_TS, 32'h0000_0000);
    add_write(pfd_pkg::REG_DERIV_ALPHA,   32'h0001_0000);
    add_write(pfd_pkg::REG_KI_TS,         32'h0001_0000);
    add_write(pfd_pkg::REG_OUT_MAX,       32'h000A_0000);
    add_write(pfd_pkg::REG_OUT_MIN,       32'hFFF6_0000);
    repeat (2) add_sample(32'h0008_0000, 1'b0, '0, 1'b0, 1'b0);
    repeat (2) add_sample(32'hFFF8_0000, 1'b0, '0, 1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  initial begin
    request_note_t note;
    bit            prev_write;
    int            ph, k;

    rst_ni        = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= pfd_pkg::REG_KP;
    cfg_data_i   <= '0;
    err_if.valid <= 1'b0;
    err_if.error <= '0;

    shadow_cfg               = '0;
    shadow_cfg.deriv_alpha   = pfd_pkg::OneQ16;
    shadow_cfg.deriv_limit   = 31'h7FFF_FFFF;
    shadow_cfg.out_max       = 32'h7FFF_FFFF;
    shadow_cfg.out_min       = 32'h8000_0000;
    integ_acc     = 0;
    prev_err      = 0;
    filt_deriv    = 0;
    fail_count    = 0;
    requests_sent = 0;
    results_seen  = 0;
    limited_seen  = 0;
    windup_seen   = 0;
    settings_used = 1;
    err_walk      = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    prev_write    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        if (!prev_write) wait_all_results();
        write_reg(stim_rows[i].idx, stim_rows[i].value);
        prev_write = 1'b1;
      end else begin
        if (prev_write) begin
          cfg_we_i <= 1'b0;
          settings_used++;
        end
        note.typed = stim_rows[i].typed;
        note.res   = stim_rows[i].res;
        send_request(stim_rows[i].value, note);
        prev_write = 1'b0;
      end
    end

    note = '0;
    for (ph = 0; ph < RAND_SETTINGS; ph++) begin
      wait_all_results();
      apply_random_settings();
      // last setting runs with no idling on either side
      if (ph == RAND_SETTINGS - 1) idle_on = 1'b0;
      for (k = 0; k < REQS_PER_SET; k++) begin
        // result side stalls while requests keep coming, so the unit backs up
        if (ph == HOLD_SETTING && k == 20) hold_req = 1'b1;
        // request side pauses until the unit has drained
        if (ph == PAUSE_SETTING && k == REQS_PER_SET / 2) wait_all_results();
        send_request(next_error(), note);
      end
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d error requests over %0d register settings, %0d results checked.",
             requests_sent, settings_used, results_seen);
    $display("Output clamped on %0d results, integral back-calculated on %0d.",
             limited_seen, windup_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random idling and one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake monitor, result check and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_block
    drive_result_t predicted, want, got;
    request_note_t note;
    bit            moved;
    moved = 1'b0;

    if (rst_ni && err_if.valid && err_if.ready) begin
      moved     = 1'b1;
      predicted = step_controller(err_if.error);
      note      = request_notes.pop_front();
      pending_drive.push_back(note.typed ? note.res : predicted);
    end

    if (rst_ni && res_if.valid && res_if.ready) begin
      moved               = 1'b1;
      got.drive           = res_if.drive;
      got.limited         = res_if.limited;
      got.windup_held     = res_if.windup_held;
      results_seen++;
      if (got.limited)     limited_seen++;
      if (got.windup_held) windup_seen++;
      if (pending_drive.size() == 0) begin
        $display("%0t: result with no request outstanding: drive %h limited %b held %b",
                 $time, got.drive, got.limited, got.windup_held);
        fail_count++;
      end else begin
        want = pending_drive.pop_front();
        if (got.drive !== want.drive) begin
          $display("%0t: drive mismatch: expected %h, actual %h",
                   $time, want.drive, got.drive);
          fail_count++;
        end
        if (got.limited !== want.limited) begin
          $display("%0t: limited mismatch: expected %b, actual %b",
                   $time, want.limited, got.limited);
          fail_count++;
        end
        if (got.windup_held !== want.windup_held) begin
          $display("%0t: windup_held mismatch: expected %b, actual %b",
                   $time, want.windup_held, got.windup_held);
          fail_count++;
        end
      end
    end

    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_drive.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial stall_cycles = 0;

endmodule

/* files.f */
rtl/core/pfd_pkg.sv
rtl/core/pfd_in_if.sv
rtl/core/pfd_out_if.sv
rtl/core/pfd_seq.sv
rtl/core/pfd_dp.sv
rtl/core/pid_filtered_derivative_antiwindup_unit.sv
tb/pid_filtered_derivative_antiwindup_unit_tb.sv
